// File: rtl/hbsd_pkg.sv
// shared types and constants for the bit-serial canonical huffman decoder
// used by hbsd_match and the core under rtl; depends on nothing else
package hbsd_pkg;

    localparam int MAX_CODE_LENGTH = 16;
    localparam int MAX_SYMBOLS     = 256;

    localparam int LEN_AW   = $clog2(MAX_CODE_LENGTH);
    localparam int SYM_AW   = $clog2(MAX_SYMBOLS);
    localparam int SYM_W    = 8;
    localparam int CNT_W    = 8;
    localparam int ACC_W    = MAX_CODE_LENGTH;
    localparam int FC_W     = MAX_CODE_LENGTH + 1;
    localparam int FI_W     = SYM_AW + 1;
    localparam int TOTAL_W  = 9;
    localparam int SUM_W    = $clog2(MAX_CODE_LENGTH * 255 + 1);
    localparam int CODE_W   = MAX_CODE_LENGTH + 2;
    localparam int POS_W    = SYM_AW + 2;

    typedef enum logic [1:0] {
        OP_LOAD_COUNT  = 2'd0,
        OP_LOAD_SYMBOL = 2'd1,
        OP_BUILD       = 2'd2,
        OP_DECODE      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_OVERSUB = 2'd1,
        ERR_COUNT   = 2'd2,
        ERR_INVALID = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_LOOKUP,
        ST_REPLY
    } state_t;

    // one row of the per-length decode table
    typedef struct packed {
        logic [FC_W-1:0]  first_code;
        logic [FI_W-1:0]  first_index;
        logic [CNT_W-1:0] count;
    } tbl_entry_t;

    localparam int TBL_W = $bits(tbl_entry_t);

    typedef struct packed {
        logic              hit;
        logic              pos_ok;
        logic [SYM_AW-1:0] pos;
    } match_t;

endpackage

// File: rtl/hbsd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module hbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/hbsd_match.sv
// compares a collected code against one length's table row
// depends on hbsd_pkg
module hbsd_match
    import hbsd_pkg::*;
(
    input  logic [ACC_W-1:0] acc,
    input  tbl_entry_t       entry,
    output match_t           m
);

    logic [FC_W-1:0]  acc_ext;
    logic [FC_W-1:0]  diff;
    logic             ge;
    logic [POS_W-1:0] pos_sum;

    assign acc_ext = {1'b0, acc};
    assign ge      = acc_ext >= entry.first_code;
    assign diff    = acc_ext - entry.first_code;
    // diff is below count when it hits, so its low byte is the offset
    assign pos_sum = POS_W'(entry.first_index) + POS_W'(diff[CNT_W-1:0]);

    assign m.hit    = ge && (diff < FC_W'(entry.count));
    assign m.pos_ok = (pos_sum[POS_W-1:SYM_AW] == '0);
    assign m.pos    = pos_sum[SYM_AW-1:0];

endmodule

// File: rtl/huffman_bit_serial_decoder_core.sv
// top level of the bit-serial canonical huffman decoder
// depends on hbsd_pkg, hbsd_ram and hbsd_match

// One word in, one word out. A count or symbol load goes straight to the reply
// state; a decode bit does one read of the per-length table ram, then one read
// of the symbol ram; a build walks the 16 code lengths one per cycle through
// the table ram's write port. Any reply waits while the previous result is
// still waiting on out_ready. A new word is taken only when the previous one
// is finished. Errors are sticky until the next good build; decoding to a
// symbol position never loaded returns an arbitrary byte.
module huffman_bit_serial_decoder_core
    import hbsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [7:0]         slot,
    input  logic [7:0]         payload,
    input  logic [TOTAL_W-1:0] symbol_total,
    input  logic               code_bit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               symbol_ready,
    output logic [SYM_W-1:0]   symbol,
    output logic [1:0]         error_code
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   length_counts_reg [MAX_CODE_LENGTH];
    logic               lc_we;

    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic [LEN_AW-1:0]  bits_taken_reg, bits_taken_next;
    logic               table_valid_reg, table_valid_next;
    logic               failed_reg, failed_next;
    err_t               err_reg, err_next;

    logic               bit_reg, bit_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LEN_AW-1:0]  step_reg, step_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               over_reg, over_next;
    logic               hit_reg, hit_next;
    logic               pos_ok_reg, pos_ok_next;
    logic [SYM_AW-1:0]  pos_reg, pos_next;

    logic               out_valid_reg, out_valid_next;
    logic               symbol_ready_reg, symbol_ready_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    err_t               error_code_reg, error_code_next;

    logic               tbl_we;
    tbl_entry_t         tbl_wdata;
    tbl_entry_t         tbl_rdata;
    logic [TBL_W-1:0]   tbl_rdata_raw;
    logic               sym_we;
    logic [SYM_AW-1:0]  sym_raddr;
    logic [SYM_W-1:0]   sym_rdata;

    logic [ACC_W-1:0]   acc_new;
    match_t             m;
    logic [CNT_W-1:0]   step_count;
    logic [CODE_W-1:0]  code_plus;
    logic [CODE_W-1:0]  code_limit;
    logic               step_over;

    // per-length table: first code, first symbol index and count
    hbsd_ram #(
        .WIDTH(TBL_W),
        .DEPTH(MAX_CODE_LENGTH)
    ) u_tbl_ram (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(step_reg),
        .wdata(tbl_wdata),
        .raddr(bits_taken_reg),
        .rdata(tbl_rdata_raw)
    );

    assign tbl_rdata = tbl_entry_t'(tbl_rdata_raw);

    hbsd_ram #(
        .WIDTH(SYM_W),
        .DEPTH(MAX_SYMBOLS)
    ) u_sym_ram (
        .clk  (clk),
        .we   (sym_we),
        .waddr(slot[SYM_AW-1:0]),
        .wdata(payload),
        .raddr(sym_raddr),
        .rdata(sym_rdata)
    );

    assign acc_new = {accum_reg[ACC_W-2:0], bit_reg};

    hbsd_match u_match (
        .acc  (acc_new),
        .entry(tbl_rdata),
        .m    (m)
    );

    // build step arithmetic for the length at step_reg
    assign step_count = length_counts_reg[step_reg];
    assign code_plus  = code_reg + CODE_W'(step_count);
    assign code_limit = CODE_W'(1) << ({1'b0, step_reg} + (LEN_AW+1)'(1));
    assign step_over  = code_plus > code_limit;

    assign tbl_wdata.first_code  = code_reg[FC_W-1:0];
    assign tbl_wdata.first_index = sum_reg[FI_W-1:0];
    assign tbl_wdata.count       = step_count;

    // hold the symbol address through the reply so the read data stays put
    assign sym_raddr = (state_reg == ST_LOOKUP) ? m.pos : pos_reg;

    always_comb
    begin
        state_next        = state_reg;
        in_ready          = 1'b0;
        lc_we             = 1'b0;
        sym_we            = 1'b0;
        tbl_we            = 1'b0;
        accum_next        = accum_reg;
        bits_taken_next   = bits_taken_reg;
        table_valid_next  = table_valid_reg;
        failed_next       = failed_reg;
        err_next          = err_reg;
        bit_next          = bit_reg;
        total_next        = total_reg;
        step_next         = step_reg;
        sum_next          = sum_reg;
        code_next         = code_reg;
        over_next         = over_reg;
        hit_next          = hit_reg;
        pos_ok_next       = pos_ok_reg;
        pos_next          = pos_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        symbol_ready_next = symbol_ready_reg;
        symbol_next       = symbol_reg;
        error_code_next   = error_code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    hit_next    = 1'b0;
                    pos_ok_next = 1'b0;
                    state_next  = ST_REPLY;
                    case (op_t'(opcode))
                        OP_LOAD_COUNT:
                        begin
                            if (slot[7:LEN_AW] == '0)
                            begin
                                lc_we            = 1'b1;
                                table_valid_next = 1'b0;
                            end
                        end
                        OP_LOAD_SYMBOL:
                        begin
                            sym_we           = 1'b1;
                            table_valid_next = 1'b0;
                        end
                        OP_BUILD:
                        begin
                            accum_next       = '0;
                            bits_taken_next  = '0;
                            failed_next      = 1'b0;
                            table_valid_next = 1'b0;
                            total_next       = symbol_total;
                            step_next        = '0;
                            sum_next         = '0;
                            code_next        = '0;
                            over_next        = 1'b0;
                            state_next       = ST_BUILD;
                        end
                        OP_DECODE:
                        begin
                            if (!table_valid_reg || failed_reg)
                            begin
                                err_next = ERR_INVALID;
                            end
                            else
                            begin
                                bit_next   = code_bit;
                                state_next = ST_LOOKUP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_BUILD:
            begin
                tbl_we    = 1'b1;
                sum_next  = sum_reg + SUM_W'(step_count);
                code_next = code_plus << 1;
                over_next = over_reg || step_over;
                step_next = step_reg + LEN_AW'(1);
                if (step_reg == LEN_AW'(MAX_CODE_LENGTH - 1))
                begin
                    state_next = ST_REPLY;
                    // count check wins over the oversubscription check
                    if ((sum_next != SUM_W'(total_reg)) ||
                        (total_reg > TOTAL_W'(MAX_SYMBOLS)))
                    begin
                        err_next = ERR_COUNT;
                    end
                    else if (over_next)
                    begin
                        err_next = ERR_OVERSUB;
                    end
                    else
                    begin
                        table_valid_next = 1'b1;
                        err_next         = ERR_NONE;
                    end
                end
            end

            ST_LOOKUP:
            begin
                state_next  = ST_REPLY;
                pos_next    = m.pos;
                pos_ok_next = m.pos_ok;
                if (m.hit)
                begin
                    hit_next        = 1'b1;
                    accum_next      = '0;
                    bits_taken_next = '0;
                end
                else if (bits_taken_reg == LEN_AW'(MAX_CODE_LENGTH - 1))
                begin
                    // no code matched within the longest length
                    failed_next     = 1'b1;
                    err_next        = ERR_INVALID;
                    accum_next      = '0;
                    bits_taken_next = '0;
                end
                else
                begin
                    accum_next      = acc_new;
                    bits_taken_next = bits_taken_reg + LEN_AW'(1);
                end
            end

            ST_REPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    symbol_ready_next = hit_reg;
                    symbol_next       = (hit_reg && pos_ok_reg) ? sym_rdata : '0;
                    error_code_next   = err_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CODE_LENGTH; i++)
            begin
                length_counts_reg[i] <= '0;
            end
        end
        else if (lc_we)
        begin
            length_counts_reg[slot[LEN_AW-1:0]] <= payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg        <= '0;
            bits_taken_reg   <= '0;
            table_valid_reg  <= 1'b0;
            failed_reg       <= 1'b0;
            err_reg          <= ERR_NONE;
            step_reg         <= '0;
            over_reg         <= 1'b0;
            hit_reg          <= 1'b0;
            pos_ok_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            accum_reg        <= accum_next;
            bits_taken_reg   <= bits_taken_next;
            table_valid_reg  <= table_valid_next;
            failed_reg       <= failed_next;
            err_reg          <= err_next;
            step_reg         <= step_next;
            over_reg         <= over_next;
            hit_reg          <= hit_next;
            pos_ok_reg       <= pos_ok_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg          <= bit_next;
        total_reg        <= total_next;
        sum_reg          <= sum_next;
        code_reg         <= code_next;
        pos_reg          <= pos_next;
        symbol_ready_reg <= symbol_ready_next;
        symbol_reg       <= symbol_next;
        error_code_reg   <= error_code_next;
    end

    assign out_valid    = out_valid_reg;
    assign symbol_ready = symbol_ready_reg;
    assign symbol       = symbol_reg;
    assign error_code   = error_code_reg;

    // a completed code only comes from a good table
    a_hit_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && symbol_ready |-> error_code == ERR_NONE)
        else $error("symbol delivered with a sticky error");

    a_valid_table_clean: assert property (@(posedge clk) disable iff (!rst_n)
        table_valid_reg && !failed_reg |-> err_reg == ERR_NONE)
        else $error("usable table while an error is held");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken before the first finished");

    a_lookup_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |-> $past(in_valid && in_ready) &&
            $past(opcode) == OP_DECODE)
        else $error("table lookup without a decode word");

endmodule

// File: test/tb_top.sv
// testbench for huffman_bit_serial_decoder_core: table loads, builds and bit-serial decode
// each output word is checked against a behavioral decoder; depends on hbsd_pkg and the rtl
module tb_top
    import hbsd_pkg::*;
();

    localparam int LIMIT        = 2_000_000;
    localparam int RANDOM_WORDS = 1300;

    typedef struct packed {
        logic       rdy;
        logic [7:0] sym;
        err_t       err;
    } decode_out_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode       = OP_LOAD_COUNT;
    logic [7:0]         slot         = 8'd0;
    logic [7:0]         payload      = 8'd0;
    logic [TOTAL_W-1:0] symbol_total = '0;
    logic               code_bit     = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               symbol_ready;
    logic [SYM_W-1:0]   symbol;
    logic [1:0]         error_code;

    huffman_bit_serial_decoder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .slot         (slot),
        .payload      (payload),
        .symbol_total (symbol_total),
        .code_bit     (code_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol_ready (symbol_ready),
        .symbol       (symbol),
        .error_code   (error_code)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decoder state as the block should hold it
    logic [7:0]  len_count  [MAX_CODE_LENGTH];
    logic [7:0]  sym_table  [MAX_SYMBOLS];
    bit          sym_loaded [MAX_SYMBOLS];
    int unsigned base_code  [MAX_CODE_LENGTH];
    int unsigned base_index [MAX_CODE_LENGTH];
    int unsigned accum;
    int unsigned taken;
    bit          table_ok;
    bit          stream_dead;
    err_t        sticky_err;

    decode_out_t decoder_out_q[$];
    decode_out_t want;

    logic [7:0]  plan [MAX_CODE_LENGTH];
    int          plan_total;
    int          last_total;
    bit          no_gaps;
    int          failures;
    int          live_words;
    int          builds;
    int          good_builds;
    int          symbols_seen;
    int          invalid_seen;
    int          cycles;
    int          stall_left;

    function automatic err_t check_table(int unsigned total);
        int unsigned sum;
        int unsigned code;
        sum = 0;
        for (int i = 0; i < MAX_CODE_LENGTH; i++)
            sum += len_count[i];
        if (sum != total || total > MAX_SYMBOLS)
            return ERR_COUNT;
        code = 0;
        for (int i = 0; i < MAX_CODE_LENGTH; i++)
        begin
            code += len_count[i];
            if (code > (32'd1 << (i + 1)))
                return ERR_OVERSUB;
            code = code << 1;
        end
        return ERR_NONE;
    endfunction

    function automatic int table_symbols();
        int n;
        n = 0;
        for (int i = 0; i < MAX_CODE_LENGTH; i++)
            n += len_count[i];
        return n;
    endfunction

    // advances the decoder state by one word and returns the word it should emit
    function automatic decode_out_t step_decoder(op_t op, logic [7:0] sl, logic [7:0] pl,
                                                 logic [8:0] total, logic b);
        decode_out_t r;
        int unsigned code;
        int unsigned sum;
        int unsigned len;
        int unsigned pos;
        r.rdy = 1'b0;
        r.sym = 8'd0;
        case (op)
            OP_LOAD_COUNT:
                if (sl < MAX_CODE_LENGTH)
                begin
                    len_count[sl] = pl;
                    table_ok = 1'b0;
                end
            OP_LOAD_SYMBOL:
            begin
                sym_table[sl] = pl;
                sym_loaded[sl] = 1'b1;
                table_ok = 1'b0;
            end
            OP_BUILD:
            begin
                accum = 0;
                taken = 0;
                stream_dead = 1'b0;
                table_ok = 1'b0;
                sticky_err = check_table(total);
                if (sticky_err == ERR_NONE)
                begin
                    code = 0;
                    sum = 0;
                    for (int i = 0; i < MAX_CODE_LENGTH; i++)
                    begin
                        base_code[i] = code;
                        base_index[i] = sum;
                        code = (code + len_count[i]) << 1;
                        sum += len_count[i];
                    end
                    table_ok = 1'b1;
                end
            end
            default:
                if (!table_ok || stream_dead)
                    sticky_err = ERR_INVALID;
                else
                begin
                    accum = ((accum << 1) | b) & 32'hffff;
                    taken++;
                    len = taken - 1;
                    if (len < MAX_CODE_LENGTH && accum >= base_code[len] &&
                        accum - base_code[len] < len_count[len])
                    begin
                        pos = base_index[len] + accum - base_code[len];
                        if (pos < MAX_SYMBOLS)
                            r.sym = sym_table[pos];
                        r.rdy = 1'b1;
                        accum = 0;
                        taken = 0;
                    end
                    else if (taken >= MAX_CODE_LENGTH)
                    begin
                        stream_dead = 1'b1;
                        sticky_err = ERR_INVALID;
                        accum = 0;
                        taken = 0;
                    end
                end
        endcase
        r.err = sticky_err;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (no_gaps || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    task automatic send_word(op_t op, logic [7:0] sl, logic [7:0] pl, logic [8:0] total,
                             logic b);
        int gap;
        in_valid <= 1'b1;
        opcode <= op;
        slot <= sl;
        payload <= pl;
        symbol_total <= total;
        code_bit <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (!((op == OP_DECODE && (!table_ok || stream_dead)) ||
              (op == OP_LOAD_COUNT && sl >= MAX_CODE_LENGTH)))
            live_words++;
        if (op == OP_BUILD)
            builds++;
        decoder_out_q.push_back(step_decoder(op, sl, pl, total, b));
        if (op == OP_BUILD && table_ok)
            good_builds++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_count(logic [7:0] len_slot, logic [7:0] count);
        send_word(OP_LOAD_COUNT, len_slot, count, TOTAL_W'($urandom), 1'($urandom));
    endtask

    task automatic put_symbol(logic [7:0] pos, logic [7:0] value);
        send_word(OP_LOAD_SYMBOL, pos, value, TOTAL_W'($urandom), 1'($urandom));
    endtask

    task automatic send_bit(logic b);
        send_word(OP_DECODE, 8'($urandom), 8'($urandom), TOTAL_W'($urandom), b);
    endtask

    // a good build must never let a code land on a symbol entry that was never loaded
    task automatic run_build(int total);
        if (check_table(total) == ERR_NONE)
            for (int p = 0; p < total; p++)
                if (!sym_loaded[p])
                    put_symbol(8'(p), 8'($urandom));
        last_total = total;
        send_word(OP_BUILD, 8'($urandom), 8'($urandom), TOTAL_W'(total), 1'($urandom));
    endtask

    // sends the canonical code of list position idx, msb first
    task automatic send_code(int idx);
        int len;
        int unsigned code;
        len = 0;
        while (len < MAX_CODE_LENGTH - 1 &&
               !(idx >= base_index[len] && idx < base_index[len] + len_count[len]))
            len++;
        code = base_code[len] + idx - base_index[len];
        for (int b = len; b >= 0; b--)
            send_bit(code[b]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoder_out_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic make_plan();
        int room;
        int left;
        int cap;
        int c;
        int start;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 256) : $urandom_range(0, 24);
        start = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
        room = 2;
        plan_total = 0;
        for (int i = 0; i < MAX_CODE_LENGTH; i++)
        begin
            cap = room;
            if (cap > left)
                cap = left;
            if (cap > 255)
                cap = 255;
            c = (i < start || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, cap);
            // close the tree so the all-ones code exists
            if (i >= start && room <= left && room <= 255 && $urandom_range(0, 4) == 0)
                c = room;
            // rare wild count, usually oversubscribed
            if ($urandom_range(0, 40) == 0)
                c = $urandom_range(0, 255);
            plan[i] = 8'(c);
            left = (left > c) ? left - c : 0;
            room = (room > c) ? (room - c) * 2 : 0;
            if (room > (1 << 17))
                room = 1 << 17;
            plan_total += c;
        end
    endtask

    task automatic test_no_table();
        send_bit(1'b1);
    endtask

    task automatic test_empty_table();
        run_build(0);
        repeat (MAX_CODE_LENGTH) send_bit(1'($urandom));
        send_bit(1'b0);
    endtask

    task automatic test_bad_tables();
        put_count(8'd200, 8'd255);
        run_build(256);
        run_build(511);
        put_count(8'd0, 8'd3);
        run_build(3);
        put_count(8'd0, 8'd255);
        put_count(8'd1, 8'd1);
        run_build(256);
    endtask

    task automatic test_small_table();
        put_count(8'd0, 8'd1);
        put_count(8'd2, 8'd2);
        put_symbol(8'd0, 8'h00);
        put_symbol(8'd1, 8'hff);
        put_symbol(8'd2, 8'h5a);
        put_symbol(8'd3, 8'ha5);
        put_symbol(8'd255, 8'h81);
        run_build(4);
        for (int i = 0; i < 4; i++)
            send_code(i);
        send_bit(1'b1);
        // a load drops the table, so the next bit is refused
        put_count(8'd3, 8'd0);
        send_bit(1'b1);
    endtask

    task automatic decode_stream(int words);
        int r;
        int n;
        for (int k = 0; k < words; k++)
        begin
            r = $urandom_range(0, 99);
            n = table_symbols();
            if (!table_ok || stream_dead)
            begin
                send_bit(1'($urandom));
                run_build(last_total);
            end
            else if (r < 84)
            begin
                if (n > 0)
                    send_code($urandom_range(0, n - 1));
                else
                    send_bit(1'($urandom));
            end
            else if (r < 92)
            begin
                repeat ($urandom_range(1, 18)) send_bit(1'($urandom));
                if (taken != 0 && $urandom_range(0, 1) == 0)
                    run_build(last_total);
            end
            else if (r < 96)
            begin
                send_bit(1'($urandom));
                run_build(last_total);
            end
            else
                put_symbol(8'($urandom_range(0, (n > 0 && n <= MAX_SYMBOLS) ? n - 1 : 0)),
                           8'($urandom));
        end
    endtask

    task automatic test_random_tables();
        int start_words;
        int total;
        int r;
        start_words = live_words;
        while (live_words - start_words < RANDOM_WORDS)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            make_plan();
            for (int i = 0; i < MAX_CODE_LENGTH; i++)
                put_count(8'(i), plan[i]);
            if ($urandom_range(0, 3) == 0)
                put_count(8'($urandom_range(MAX_CODE_LENGTH, 255)), 8'($urandom));
            for (int p = 0; p < plan_total && p < MAX_SYMBOLS; p++)
                put_symbol(8'(p), 8'($urandom));
            total = plan_total;
            r = $urandom_range(0, 99);
            if (r < 6)
                total = $urandom_range(257, 511);
            else if (r < 12)
                total = plan_total + 1;
            run_build(total);
            decode_stream($urandom_range(20, 60));
            if ($urandom_range(0, 3) == 0)
                wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (no_gaps)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            stall_left = idle_len() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            if (decoder_out_q.size() == 0)
            begin
                $display("%0t: output word with nothing expected: ready=%0d symbol=%02h %s%0d",
                         $time, symbol_ready, symbol, "error=", error_code);
                failures++;
            end
            else
            begin
                want = decoder_out_q.pop_front();
                if (symbol_ready !== want.rdy || symbol !== want.sym || error_code !== want.err)
                begin
                    $display("%0t: mismatch, expected ready=%0d symbol=%02h error=%0d, %s",
                             $time, want.rdy, want.sym, want.err, "got");
                    $display("    ready=%0d symbol=%02h error=%0d",
                             symbol_ready, symbol, error_code);
                    failures++;
                end
                if (want.rdy)
                    symbols_seen++;
                if (want.err == ERR_INVALID)
                    invalid_seen++;
            end
        end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_CODE_LENGTH; i++)
        begin
            len_count[i] = 8'd0;
            base_code[i] = 0;
            base_index[i] = 0;
        end
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym_table[i] = 8'd0;
            sym_loaded[i] = 1'b0;
        end
        accum = 0;
        taken = 0;
        table_ok = 1'b0;
        stream_dead = 1'b0;
        sticky_err = ERR_NONE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_table();
        test_empty_table();
        test_bad_tables();
        test_small_table();
        wait_idle();
        test_random_tables();
        wait_idle();
        repeat (40) @(posedge clk);
        $display("covered %0d live words over %0d builds (%0d good)", live_words, builds,
                 good_builds);
        $display("%0d symbols decoded, %0d words flagged invalid code or no table",
                 symbols_seen, invalid_seen);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
